### src/mkd_pkg.sv
// mkd_pkg: shared types, widths and the A-Z Morse table for the Morse key decoder.
// Used by mkd_match and morse_key_decoder; depends on nothing.
package mkd_pkg;

	localparam int MAX_SYMBOLS = 8;
	localparam int WORD_DEPTH  = 16;
	localparam int LETTERS     = 26;

	localparam int SYM_CNT_W  = 4;
	localparam int PAT_W      = 8;
	localparam int PAT_AW     = $clog2(PAT_W);
	localparam int WORD_LEN_W = 5;
	localparam int LETTER_W   = 5;
	localparam int IDX_W      = 4;
	localparam int STORE_AW   = $clog2(WORD_DEPTH);
	localparam int TIME_W     = 32;
	localparam int THRESH_W   = 16;

	localparam logic [THRESH_W-1:0] LONG_PRESS_RST = 16'd300;

	// symbol count and dash pattern (bit i = symbol i, 1 dash) per letter, A first
	localparam logic [SYM_CNT_W-1:0] CODE_LEN [LETTERS] = '{
		4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4, 4'd3, 4'd4, 4'd2,
		4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd1, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4
	};
	localparam logic [PAT_W-1:0] CODE_BITS [LETTERS] = '{
		8'd2, 8'd1, 8'd5, 8'd1, 8'd0, 8'd4, 8'd3, 8'd0, 8'd0, 8'd14, 8'd5, 8'd2, 8'd3,
		8'd1, 8'd7, 8'd6, 8'd11, 8'd2, 8'd0, 8'd1, 8'd4, 8'd8, 8'd6, 8'd9, 8'd13, 8'd3
	};

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;

	// input beat, last field in the lowest bits
	typedef struct packed {
		logic                 pad;
		logic [IDX_W-1:0]     read_index;
		logic [TIME_W-1:0]    time_ms;
		logic                 decode_down;
		logic                 erase_down;
		logic                 key_down;
	} in_beat_t;

	// result beat, last field in the lowest bits
	typedef struct packed {
		logic [1:0]            pad;
		logic [LETTER_W-1:0]   read_letter;
		logic                  word_full;
		logic                  decode_missed;
		logic [LETTER_W-1:0]   added_letter;
		logic                  letter_added;
		logic [WORD_LEN_W-1:0] word_length;
		logic [PAT_W-1:0]      symbol_pattern;
		logic [SYM_CNT_W-1:0]  symbol_count;
	} out_beat_t;

	typedef struct packed {
		logic                hit;
		logic [LETTER_W-1:0] letter;
	} match_t;

endpackage

### src/mkd_match.sv
// mkd_match: looks up pending Morse symbols in the A-Z table.
// Depends on mkd_pkg for the table and the match_t result.
module mkd_match (
	input  logic [mkd_pkg::SYM_CNT_W-1:0] count,
	input  logic [mkd_pkg::PAT_W-1:0]     pattern,
	output mkd_pkg::match_t               result
);
	import mkd_pkg::*;

	// walk downward so the lowest matching letter wins
	always_comb begin
		result = '0;
		for (int i = LETTERS - 1; i >= 0; i--) begin
			if (count == CODE_LEN[i] && pattern == CODE_BITS[i]) begin
				result.hit    = 1'b1;
				result.letter = LETTER_W'(i);
			end
		end
	end

endmodule

### src/morse_key_decoder.sv
// morse_key_decoder: top level of the Morse key decoder.
// Depends on mkd_pkg and mkd_match.
//
// Usage:
//   s_* carries one button poll per beat; m_* returns one result beat per poll.
//   cfg_* writes long_press_ms (always ready); write it only while the block is idle.
//   A poll lands in an input register, and the symbol, erase, decode and letter
//   store updates all happen together as it moves into the result register.
//   Throughput is one poll per cycle as long as m_tready stays high.
//   s_tready stays high while the result register is empty or being taken, so a
//   new poll is accepted while the previous result waits. When m_tready is low
//   the result holds, the input register fills and then s_tready drops.
//   Reset (arst_n low) empties both registers, clears the pending symbols, the
//   key state and the letter count, and sets long_press_ms to 300. The letter
//   store itself is not cleared; entries at or above the letter count are never
//   reported.
module morse_key_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// key_down, erase_down, decode_down, time_ms[31:0], read_index[3:0], zero pad
	input  logic [mkd_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// symbol_count[3:0], symbol_pattern[7:0], word_length[4:0], letter_added,
	// added_letter[4:0], decode_missed, word_full, read_letter[4:0], zero pad
	output logic [mkd_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mkd_pkg::THRESH_W-1:0]    cfg_data
);
	import mkd_pkg::*;

	logic                  valid_s1;
	in_beat_t              in_s1;
	logic                  out_valid_q;
	out_beat_t             out_q;

	logic [THRESH_W-1:0]   long_press_q;
	logic                  key_held_q;
	logic [TIME_W-1:0]     press_start_q;
	logic [SYM_CNT_W-1:0]  pend_cnt_q;
	logic [PAT_W-1:0]      pend_bits_q;
	logic [WORD_LEN_W-1:0] letter_cnt_q;
	logic [LETTER_W-1:0]   store_q [WORD_DEPTH];

	logic                  advance;
	logic                  step;
	logic [TIME_W-1:0]     dur;
	logic                  release_ev;
	logic [SYM_CNT_W-1:0]  cnt1, cnt2;
	logic [PAT_W-1:0]      bits1, bits2;
	logic [WORD_LEN_W-1:0] lc2, lc3;
	match_t                match;
	logic                  added, missed, full;
	logic [LETTER_W-1:0]   rd_letter;
	out_beat_t             res;

	assign advance   = !out_valid_q || m_tready;
	assign step      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	mkd_match u_match (
		.count   (cnt2),
		.pattern (bits2),
		.result  (match)
	);

	always_comb begin
		dur        = in_s1.time_ms - press_start_q;
		release_ev = !in_s1.key_down && key_held_q;

		cnt1  = pend_cnt_q;
		bits1 = pend_bits_q;
		if (release_ev && pend_cnt_q < SYM_CNT_W'(MAX_SYMBOLS)) begin
			if (dur >= {{(TIME_W-THRESH_W){1'b0}}, long_press_q})
				bits1[pend_cnt_q[PAT_AW-1:0]] = 1'b1;
			cnt1 = pend_cnt_q + 1'b1;
		end

		cnt2  = cnt1;
		bits2 = bits1;
		lc2   = letter_cnt_q;
		if (in_s1.erase_down) begin
			if (cnt1 != '0) begin
				cnt2 = cnt1 - 1'b1;
				bits2[cnt2[PAT_AW-1:0]] = 1'b0;
			end else if (letter_cnt_q != '0) begin
				lc2 = letter_cnt_q - 1'b1;
			end
		end

		added  = 1'b0;
		missed = 1'b0;
		full   = 1'b0;
		if (in_s1.decode_down) begin
			if (!match.hit)
				missed = 1'b1;
			else if (lc2 >= WORD_LEN_W'(WORD_DEPTH))
				full = 1'b1;
			else
				added = 1'b1;
		end
		lc3 = lc2 + WORD_LEN_W'(added);

		// forward the letter written by this same poll
		rd_letter = '0;
		if ({1'b0, in_s1.read_index} < lc3) begin
			if (added && in_s1.read_index == lc2[STORE_AW-1:0])
				rd_letter = match.letter;
			else
				rd_letter = store_q[in_s1.read_index];
		end

		res                = '0;
		res.symbol_count   = in_s1.decode_down ? '0 : cnt2;
		res.symbol_pattern = in_s1.decode_down ? '0 : bits2;
		res.word_length    = lc3;
		res.letter_added   = added;
		res.added_letter   = added ? match.letter : '0;
		res.decode_missed  = missed;
		res.word_full      = full;
		res.read_letter    = rd_letter;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			long_press_q  <= LONG_PRESS_RST;
			key_held_q    <= 1'b0;
			press_start_q <= '0;
			pend_cnt_q    <= '0;
			pend_bits_q   <= '0;
			letter_cnt_q  <= '0;
		end else begin
			if (cfg_valid)
				long_press_q <= cfg_data;
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (step)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= valid_s1;
			if (step) begin
				if (in_s1.key_down) begin
					if (!key_held_q) begin
						key_held_q    <= 1'b1;
						press_start_q <= in_s1.time_ms;
					end
				end else begin
					key_held_q <= 1'b0;
				end
				pend_cnt_q   <= res.symbol_count;
				pend_bits_q  <= res.symbol_pattern;
				letter_cnt_q <= lc3;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			in_s1 <= s_tdata;
		if (step)
			out_q <= res;
		if (step && added)
			store_q[lc2[STORE_AW-1:0]] <= match.letter;
	end

	a_sym_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q <= SYM_CNT_W'(MAX_SYMBOLS))
		else $error("pending symbol count above limit");

	a_word_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		letter_cnt_q <= WORD_LEN_W'(WORD_DEPTH))
		else $error("letter count above store depth");

	a_bits_above_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_bits_q >> pend_cnt_q) == '0)
		else $error("pattern bit set beyond pending count");

	a_add_xor_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.letter_added && (out_q.word_full || out_q.decode_missed)))
		else $error("letter added together with a decode failure flag");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> $stable(letter_cnt_q) && $stable(pend_cnt_q))
		else $error("state changed while result stalled");

endmodule
